FILE: sv/ofd_pkg.sv
// ofd_pkg: shared constants for the on-off keyed remote frame decoder
// operation codes, register indexes, reset values and the timing set table
// no dependencies
`default_nettype none

package ofd_pkg;

    localparam int DEF_PULSE_DEPTH   = 256;
    localparam int DEF_DURATION_BITS = 24;

    localparam logic [1:0] OP_RECORD   = 2'd0;
    localparam logic [1:0] OP_DECODE   = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] REG_TOLERANCE = 2'd0;
    localparam logic [1:0] REG_BASE_MIN  = 2'd1;
    localparam logic [1:0] REG_BASE_MAX  = 2'd2;
    localparam logic [1:0] REG_MIN_FRAME = 2'd3;

    localparam logic [6:0]  RST_TOLERANCE = 7'd25;
    localparam logic [15:0] RST_BASE_MIN  = 16'd50;
    localparam logic [15:0] RST_BASE_MAX  = 16'd2000;
    localparam logic [8:0]  RST_MIN_FRAME = 9'd8;

    // x / 100 for x below 2^28 as (x * PCT_RECIP) >> 35
    localparam logic [28:0] PCT_RECIP = 29'd343597384;
    localparam int NUM_SETS = 3;

    // sync low widths at or above 2^23 always give a base above 16 bits
    localparam int SL_IN_W = 23;
    localparam logic [31:0] SL_QUOT_SAT = 32'h0100_0000;

    // per timing set: protocol id, frame bits, sync low ratio, long bit ratio
    // sync high, short bit halves are one base unit in every set
    localparam logic [1:0] SET_ID   [NUM_SETS] = '{2'd1, 2'd2, 2'd3};
    localparam logic [4:0] SET_BITS [NUM_SETS] = '{5'd24, 5'd24, 5'd28};
    localparam logic [6:0] SET_SL   [NUM_SETS] = '{7'd31, 7'd31, 7'd23};
    localparam logic [1:0] SET_K    [NUM_SETS] = '{2'd3, 2'd3, 2'd2};
    // x / sync low ratio for x below 2^23 as (x * SET_SL_RECIP) >> 28
    localparam logic [23:0] SET_SL_RECIP [NUM_SETS] =
        '{24'd8659209, 24'd8659209, 24'd11671107};

endpackage

`default_nettype wire

FILE: sv/ook_remote_frame_decoder_top.sv
// ook_remote_frame_decoder_top: pulse ring, frame search sequencer, reciprocal multipliers
// depends on ofd_pkg and ofd_ram
//
// usage
//   input channel (in_valid/in_ready) carries operation and edge_time_us.
//   record edge and clear never leave the idle state; in_ready stays high after them.
//   a decode request drops in_ready while the sequencer walks the ring and
//   ends with one transaction on the output channel (out_valid/out_ready).
//   other operations give no output transaction.
//   decode: when too few pulses are stored the request goes straight to the
//   output state, otherwise the sequencer tries each of the three timing sets
//   at each start position; the divisions by the sync ratio and by 100 are
//   reciprocal multiplications.
//   the result waits in an output register; new items are taken while it
//   waits, a later decode holds in its final state until the register frees.
//   config port (cfg_valid/cfg_ready) is always ready, write only when idle.
//   reset clears pointers, count, edge reference, latches and config; the
//   ring needs no clearing since only entries written since clear are read.
`default_nettype none

module ook_remote_frame_decoder_top
    import ofd_pkg::*;
#(
    parameter int PULSE_DEPTH   = DEF_PULSE_DEPTH,
    parameter int DURATION_BITS = DEF_DURATION_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] edge_time_us,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       protocol,
    output logic [27:0]      frame_code,
    output logic [4:0]       frame_bits,
    output logic             found_now,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int PTR_W = $clog2(PULSE_DEPTH);
    localparam int CNT_W = $clog2(PULSE_DEPTH + 1);
    localparam int OFF_W = CNT_W + 1;
    localparam int DW    = DURATION_BITS;
    localparam int EW    = 21;   // base (16 bit) times ratio up to 31
    localparam int BW    = 23;   // expected plus tolerance
    localparam int SLP_W = 47;   // sync low operand times its reciprocal
    localparam int PCP_W = 57;   // tolerance product times reciprocal of 100

    typedef enum logic [3:0] {
        S_IDLE, S_POS, S_RDH, S_RDL, S_CHK0, S_DIVL, S_BASE, S_TOLMUL,
        S_TOLDIV, S_TOLSET, S_SYNC, S_BRH, S_BRL, S_BCHK, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      last_reg, last_next;
    logic             have_reg, have_next;
    logic [1:0]       lprot_reg, lprot_next;
    logic [27:0]      lcode_reg, lcode_next;
    logic [4:0]       lbits_reg, lbits_next;

    logic             oval_reg, oval_next;
    logic [1:0]       oprot_reg, oprot_next;
    logic [27:0]      ocode_reg, ocode_next;
    logic [4:0]       obits_reg, obits_next;
    logic             ofound_reg, ofound_next;

    logic [6:0]       tol_reg, tol_next;
    logic [15:0]      bmin_reg, bmin_next;
    logic [15:0]      bmax_reg, bmax_next;
    logic [8:0]       minf_reg, minf_next;

    logic [1:0]       set_reg, set_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [4:0]       bit_reg, bit_next;
    logic [PTR_W-1:0] oldest_reg, oldest_next;
    logic [DW-1:0]    h_reg, h_next;
    logic [DW-1:0]    l_reg, l_next;
    logic [DW-1:0]    bh_reg, bh_next;
    logic [27:0]      code_reg, code_next;
    logic             found_reg, found_next;
    logic [15:0]      base_reg, base_next;
    logic [EW-1:0]    e_reg  [3];
    logic [EW-1:0]    e_next [3];
    logic [BW-1:0]    lo_reg [3];
    logic [BW-1:0]    lo_next[3];
    logic [BW-1:0]    hi_reg [3];
    logic [BW-1:0]    hi_next[3];
    logic [1:0]       tsel_reg, tsel_next;

    // shared operand register: sync low quotient, tolerance product, tolerance
    logic [31:0]      dq_reg, dq_next;

    // reciprocal multiplications
    logic [SL_IN_W-1:0] l_small;
    logic               l_big;
    logic [SLP_W-1:0]   sl_prod;
    logic [31:0]        sl_quot;
    logic [PCP_W-1:0]   pct_prod;
    logic [27:0]        tol_q;

    // ring ram
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [DW-1:0]    ram_wdata;
    logic [PTR_W-1:0] ram_raddr;
    logic [DW-1:0]    ram_rdata;

    logic             in_acc;
    logic [31:0]      delta;
    logic [32:0]      max_dur;
    logic [OFF_W-1:0] needed;
    logic [32:0]      base_sum;
    logic [31:0]      base_full;
    logic [EW-1:0]    e_sel;
    logic [OFF_W:0]   oldest_tmp;

    function automatic logic [PTR_W-1:0] ring_idx(input logic [PTR_W-1:0] old,
                                                  input logic [OFF_W-1:0] off);
        logic [OFF_W:0] s;
        s = (OFF_W+1)'(old) + (OFF_W+1)'(off);
        if (s >= (OFF_W+1)'(PULSE_DEPTH))
        begin
            s = s - (OFF_W+1)'(PULSE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic near(input logic [DW-1:0] m, input logic [BW-1:0] lo,
                                  input logic [BW-1:0] hi, input logic [15:0] b);
        return (b != 16'd0) && (33'(m) >= 33'(lo)) && (33'(m) <= 33'(hi));
    endfunction

    ofd_ram #(
        .WIDTH(DW),
        .DEPTH(PULSE_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = oval_reg;
    assign protocol   = oprot_reg;
    assign frame_code = ocode_reg;
    assign frame_bits = obits_reg;
    assign found_now  = ofound_reg;

    // sync low / ratio, exact below 2^23; larger values force a rejected base
    assign l_small  = SL_IN_W'(l_reg);
    assign l_big    = (32'(l_reg) >> SL_IN_W) != 32'd0;
    assign sl_prod  = SLP_W'(l_small) * SLP_W'(SET_SL_RECIP[set_reg]);
    assign sl_quot  = l_big ? SL_QUOT_SAT : 32'(sl_prod[SLP_W-1:28]);
    // tolerance product / 100, exact below 2^28
    assign pct_prod = PCP_W'(dq_reg[27:0]) * PCP_W'(PCT_RECIP);
    assign tol_q    = 28'(pct_prod[PCP_W-1:35]);

    assign delta     = edge_time_us - last_reg;
    assign max_dur   = (33'd1 << DURATION_BITS) - 33'd1;
    assign needed    = OFF_W'(7'd2 + {1'b0, SET_BITS[set_reg], 1'b0});
    assign base_sum  = 33'(h_reg) + 33'(dq_reg);
    assign base_full = base_sum[32:1];
    assign e_sel     = e_reg[tsel_reg];
    assign oldest_tmp = (OFF_W+1)'(wp_reg) + (OFF_W+1)'(PULSE_DEPTH)
                        - (OFF_W+1)'(cnt_reg);

    assign ram_we    = in_acc && (operation == OP_RECORD) && have_reg;
    assign ram_waddr = wp_reg;
    assign ram_wdata = ({1'b0, delta} > max_dur) ? max_dur[DW-1:0] : delta[DW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        have_next   = have_reg;
        lprot_next  = lprot_reg;
        lcode_next  = lcode_reg;
        lbits_next  = lbits_reg;
        oval_next   = oval_reg && !out_ready;
        oprot_next  = oprot_reg;
        ocode_next  = ocode_reg;
        obits_next  = obits_reg;
        ofound_next = ofound_reg;
        tol_next    = tol_reg;
        bmin_next   = bmin_reg;
        bmax_next   = bmax_reg;
        minf_next   = minf_reg;
        set_next    = set_reg;
        pos_next    = pos_reg;
        bit_next    = bit_reg;
        oldest_next = oldest_reg;
        h_next      = h_reg;
        l_next      = l_reg;
        bh_next     = bh_reg;
        code_next   = code_reg;
        found_next  = found_reg;
        base_next   = base_reg;
        e_next      = e_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        tsel_next   = tsel_reg;
        dq_next     = dq_reg;
        ram_raddr   = ring_idx(oldest_reg, OFF_W'(pos_reg));

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TOLERANCE: tol_next  = cfg_data[6:0];
                REG_BASE_MIN:  bmin_next = cfg_data;
                REG_BASE_MAX:  bmax_next = cfg_data;
                REG_MIN_FRAME: minf_next = cfg_data[8:0];
                default:       tol_next  = tol_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (operation)
                        OP_RECORD:
                        begin
                            have_next = 1'b1;
                            last_next = edge_time_us;
                            if (have_reg)
                            begin
                                wp_next = (wp_reg == PTR_W'(PULSE_DEPTH - 1)) ?
                                          '0 : wp_reg + 1'b1;
                                if (cnt_reg != CNT_W'(PULSE_DEPTH))
                                begin
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            wp_next    = '0;
                            cnt_next   = '0;
                            last_next  = '0;
                            have_next  = 1'b0;
                            lprot_next = '0;
                            lcode_next = '0;
                            lbits_next = '0;
                        end
                        OP_DECODE:
                        begin
                            found_next  = 1'b0;
                            set_next    = '0;
                            pos_next    = '0;
                            oldest_next = (oldest_tmp >= (OFF_W+1)'(PULSE_DEPTH)) ?
                                PTR_W'(oldest_tmp - (OFF_W+1)'(PULSE_DEPTH)) :
                                PTR_W'(oldest_tmp);
                            if (32'(cnt_reg) >= 32'(minf_reg))
                            begin
                                state_next = S_POS;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            have_next = have_reg;
                        end
                    endcase
                end
            end
            S_POS:
            begin
                if ((OFF_W'(pos_reg) + needed) <= OFF_W'(cnt_reg))
                begin
                    state_next = S_RDH;
                end
                else if (set_reg == 2'(NUM_SETS - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    set_next = set_reg + 1'b1;
                    pos_next = '0;
                end
            end
            S_RDH:
            begin
                ram_raddr  = ring_idx(oldest_reg, OFF_W'(pos_reg));
                state_next = S_RDL;
            end
            S_RDL:
            begin
                ram_raddr  = ring_idx(oldest_reg, OFF_W'(pos_reg) + 1'b1);
                h_next     = ram_rdata;
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                l_next = ram_rdata;
                if (h_reg == '0 || ram_rdata == '0)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_POS;
                end
                else
                begin
                    state_next = S_DIVL;
                end
            end
            S_DIVL:
            begin
                // base needs low / sync low ratio
                dq_next    = sl_quot;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                if (base_full < 32'(bmin_reg) || base_full > 32'(bmax_reg))
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_POS;
                end
                else
                begin
                    base_next  = base_full[15:0];
                    e_next[0]  = EW'(base_full[15:0]);
                    e_next[1]  = EW'(base_full[15:0]) * EW'(SET_K[set_reg]);
                    e_next[2]  = EW'(base_full[15:0]) * EW'(SET_SL[set_reg]);
                    tsel_next  = '0;
                    state_next = S_TOLMUL;
                end
            end
            S_TOLMUL:
            begin
                dq_next    = 32'(e_sel) * 32'(tol_reg);
                state_next = S_TOLDIV;
            end
            S_TOLDIV:
            begin
                dq_next    = 32'(tol_q);
                state_next = S_TOLSET;
            end
            S_TOLSET:
            begin
                lo_next[tsel_reg] = (28'(e_sel) < dq_reg[27:0]) ? '0 :
                                    BW'(28'(e_sel) - dq_reg[27:0]);
                hi_next[tsel_reg] = BW'(28'(e_sel) + dq_reg[27:0]);
                if (tsel_reg == 2'd2)
                begin
                    state_next = S_SYNC;
                end
                else
                begin
                    tsel_next  = tsel_reg + 1'b1;
                    state_next = S_TOLMUL;
                end
            end
            S_SYNC:
            begin
                if (near(h_reg, lo_reg[0], hi_reg[0], base_reg) &&
                    near(l_reg, lo_reg[2], hi_reg[2], base_reg))
                begin
                    bit_next   = '0;
                    code_next  = '0;
                    state_next = S_BRH;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_POS;
                end
            end
            S_BRH:
            begin
                ram_raddr  = ring_idx(oldest_reg, OFF_W'(pos_reg) + OFF_W'(2)
                                      + OFF_W'({bit_reg, 1'b0}));
                state_next = S_BRL;
            end
            S_BRL:
            begin
                ram_raddr  = ring_idx(oldest_reg, OFF_W'(pos_reg) + OFF_W'(3)
                                      + OFF_W'({bit_reg, 1'b0}));
                bh_next    = ram_rdata;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (near(bh_reg, lo_reg[1], hi_reg[1], base_reg) &&
                    near(ram_rdata, lo_reg[0], hi_reg[0], base_reg))
                begin
                    code_next = {code_reg[26:0], 1'b1};
                end
                else if (near(bh_reg, lo_reg[0], hi_reg[0], base_reg) &&
                         near(ram_rdata, lo_reg[1], hi_reg[1], base_reg))
                begin
                    code_next = {code_reg[26:0], 1'b0};
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_POS;
                end
                if (state_next == S_BCHK)
                begin
                    if (bit_reg == SET_BITS[set_reg] - 5'd1)
                    begin
                        lprot_next = SET_ID[set_reg];
                        lcode_next = code_next;
                        lbits_next = SET_BITS[set_reg];
                        found_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 1'b1;
                        state_next = S_BRH;
                    end
                end
            end
            S_OUT:
            begin
                if (!oval_reg || out_ready)
                begin
                    oval_next   = 1'b1;
                    oprot_next  = lprot_reg;
                    ocode_next  = lcode_reg;
                    obits_next  = lbits_reg;
                    ofound_next = found_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            cnt_reg    <= '0;
            last_reg   <= '0;
            have_reg   <= 1'b0;
            lprot_reg  <= '0;
            lcode_reg  <= '0;
            lbits_reg  <= '0;
            oval_reg   <= 1'b0;
            oprot_reg  <= '0;
            ocode_reg  <= '0;
            obits_reg  <= '0;
            ofound_reg <= 1'b0;
            tol_reg    <= RST_TOLERANCE;
            bmin_reg   <= RST_BASE_MIN;
            bmax_reg   <= RST_BASE_MAX;
            minf_reg   <= RST_MIN_FRAME;
            set_reg    <= '0;
            pos_reg    <= '0;
            bit_reg    <= '0;
            tsel_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            have_reg   <= have_next;
            lprot_reg  <= lprot_next;
            lcode_reg  <= lcode_next;
            lbits_reg  <= lbits_next;
            oval_reg   <= oval_next;
            oprot_reg  <= oprot_next;
            ocode_reg  <= ocode_next;
            obits_reg  <= obits_next;
            ofound_reg <= ofound_next;
            tol_reg    <= tol_next;
            bmin_reg   <= bmin_next;
            bmax_reg   <= bmax_next;
            minf_reg   <= minf_next;
            set_reg    <= set_next;
            pos_reg    <= pos_next;
            bit_reg    <= bit_next;
            tsel_reg   <= tsel_next;
            found_reg  <= found_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        oldest_reg <= oldest_next;
        h_reg      <= h_next;
        l_reg      <= l_next;
        bh_reg     <= bh_next;
        code_reg   <= code_next;
        base_reg   <= base_next;
        e_reg      <= e_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        dq_reg     <= dq_next;
    end

endmodule

`default_nettype wire

FILE: sv/ofd_ram.sv
// ofd_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ofd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/ofd_checker.sv
// ofd_props: port level assertions for the remote frame decoder
// bound to ook_remote_frame_decoder_top, depends on ofd_pkg for operation codes
`default_nettype none

module ofd_props
    import ofd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  operation,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  protocol,
    input wire logic [27:0] frame_code,
    input wire logic [4:0]  frame_bits,
    input wire logic        found_now
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_code)
        && $stable(protocol) && $stable(frame_bits) && $stable(found_now))
        else $error("stalled result changed");

    // a found frame reports one of the frame lengths
    a_found_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_now |-> (frame_bits == 5'd24 || frame_bits == 5'd28)
        && protocol != 2'd0)
        else $error("found frame with bad length or protocol");

    // empty latch reports nothing
    a_empty_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_bits == 5'd0 |-> protocol == 2'd0 && frame_code == 28'd0)
        else $error("empty latch with nonzero fields");

    // only a decode takes the block busy
    a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation != OP_DECODE |=> in_ready)
        else $error("record or clear left the block busy");

endmodule

bind ook_remote_frame_decoder_top ofd_props u_ofd_props (.*);

`default_nettype wire

FILE: test/ofd_checker.sv
// ofd_checker: watches the decoder channels, predicts decode results and compares
// depends on ofd_pkg for operation and register codes
`timescale 1ns / 1ps

module ofd_checker
    import ofd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] edge_time_us,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  protocol,
    input  wire logic [27:0] frame_code,
    input  wire logic [4:0]  frame_bits,
    input  wire logic        found_now,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               errors,
    output int               pending
);

    localparam int DEPTH = 256;
    localparam longint MAX_PULSE = (64'd1 << 24) - 1;

    // timing sets in search order: protocol id, frame bits, sync low ratio, long ratio
    localparam logic [1:0] PROTO_ID [3] = '{2'd1, 2'd2, 2'd3};
    localparam int FRAME_LEN [3] = '{24, 24, 28};
    localparam int SYNC_LOW  [3] = '{31, 31, 23};
    localparam int LONG_HALF [3] = '{3, 3, 2};

    typedef struct packed {
        logic [1:0]  protocol;
        logic [27:0] code;
        logic [4:0]  bits;
        logic        found;
    } decode_result_t;

    decode_result_t expected_results[$];

    logic [6:0]  tolerance;
    logic [15:0] base_min;
    logic [15:0] base_max;
    logic [8:0]  min_frame;

    logic [23:0] pulses [DEPTH];
    logic [7:0]  wr_ptr;
    logic [8:0]  stored;
    logic [31:0] last_edge;
    logic        have_edge;
    logic [1:0]  held_protocol;
    logic [27:0] held_code;
    logic [4:0]  held_bits;

    assign pending = expected_results.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint pulse_at(input int i);
        return longint'(pulses[(int'(wr_ptr) + DEPTH - int'(stored) + i) % DEPTH]);
    endfunction

    function automatic bit near_width(input longint measured, input longint want);
        longint tol;
        longint lo;
        if (want == 0)
            return 1'b0;
        tol = want * longint'(tolerance) / 100;
        lo = (tol > want) ? 0 : want - tol;
        return measured >= lo && measured <= want + tol;
    endfunction

    function automatic bit search_set(input int s, output logic [27:0] code);
        int needed;
        longint h, l, base, bh, bl;
        bit ok;
        needed = 2 + 2 * FRAME_LEN[s];
        code = '0;
        if (int'(stored) < needed)
            return 1'b0;
        for (int i = 0; i + needed <= int'(stored); i++)
        begin
            h = pulse_at(i);
            l = pulse_at(i + 1);
            if (h == 0 || l == 0)
                continue;
            base = (h + l / SYNC_LOW[s]) / 2;
            if (base < longint'(base_min) || base > longint'(base_max))
                continue;
            if (!near_width(h, base) || !near_width(l, base * SYNC_LOW[s]))
                continue;
            ok = 1'b1;
            code = '0;
            for (int b = 0; b < FRAME_LEN[s]; b++)
            begin
                bh = pulse_at(i + 2 + 2 * b);
                bl = pulse_at(i + 3 + 2 * b);
                if (near_width(bh, base * LONG_HALF[s]) && near_width(bl, base))
                    code = {code[26:0], 1'b1};
                else if (near_width(bh, base) && near_width(bl, base * LONG_HALF[s]))
                    code = {code[26:0], 1'b0};
                else
                begin
                    ok = 1'b0;
                    break;
                end
            end
            if (ok)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_pulses();
        wr_ptr = '0;
        stored = '0;
        last_edge = '0;
        have_edge = 1'b0;
        held_protocol = '0;
        held_code = '0;
        held_bits = '0;
    endtask

    task automatic apply_item(input logic [1:0] op, input logic [31:0] t);
        longint d;
        logic [27:0] code;
        decode_result_t r;
        if (op == OP_RECORD)
        begin
            if (!have_edge)
            begin
                have_edge = 1'b1;
                last_edge = t;
                return;
            end
            d = longint'(t - last_edge);
            if (d > MAX_PULSE)
                d = MAX_PULSE;
            last_edge = t;
            pulses[wr_ptr] = d[23:0];
            wr_ptr = wr_ptr + 1'b1;
            if (stored < DEPTH)
                stored = stored + 1'b1;
        end
        else if (op == OP_CLEAR)
            clear_pulses();
        else if (op == OP_DECODE)
        begin
            r.found = 1'b0;
            if (stored >= min_frame)
            begin
                for (int s = 0; s < 3; s++)
                begin
                    if (search_set(s, code))
                    begin
                        held_protocol = PROTO_ID[s];
                        held_code = code;
                        held_bits = 5'(FRAME_LEN[s]);
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            r.protocol = held_protocol;
            r.code = held_code;
            r.bits = held_bits;
            expected_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decode_result_t want;
        if (!rst_n)
        begin
            tolerance = RST_TOLERANCE;
            base_min = RST_BASE_MIN;
            base_max = RST_BASE_MAX;
            min_frame = RST_MIN_FRAME;
            clear_pulses();
            expected_results.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TOLERANCE: tolerance = cfg_data[6:0];
                    REG_BASE_MIN:  base_min = cfg_data;
                    REG_BASE_MAX:  base_max = cfg_data;
                    REG_MIN_FRAME: min_frame = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected result", found_now, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (protocol !== want.protocol)
                        report("protocol", protocol, want.protocol);
                    if (frame_code !== want.code)
                        report("frame_code", frame_code, want.code);
                    if (frame_bits !== want.bits)
                        report("frame_bits", frame_bits, want.bits);
                    if (found_now !== want.found)
                        report("found_now", found_now, want.found);
                end
            end
            if (in_valid && in_ready)
                apply_item(operation, edge_time_us);
        end
    end

endmodule

FILE: test/tb.sv
// tb: stimulus and verdict for the on-off keyed remote frame decoder
// depends on ofd_pkg, ook_remote_frame_decoder_top and ofd_checker
`timescale 1ns / 1ps

module tb;
    import ofd_pkg::*;

    // the longest legal decode walks a full ring; allow several times its length
    localparam int STALL_LIMIT = 600000;
    localparam int ITEM_TARGET = 1050;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [31:0] edge_time_us;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  protocol;
    logic [27:0] frame_code;
    logic [4:0]  frame_bits;
    logic        found_now;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;

    // stimulus bookkeeping
    logic [31:0] now_us;     // running receiver timestamp
    int          ring_fill;  // rough count of stored pulses, keeps decodes short
    int          n_items;
    bit          calm;       // when set neither side idles
    int          hold_len;   // requested long output stall

    int          quiet_cycles;

    ook_remote_frame_decoder_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .edge_time_us(edge_time_us),
        .out_valid(out_valid), .out_ready(out_ready),
        .protocol(protocol), .frame_code(frame_code),
        .frame_bits(frame_bits), .found_now(found_now),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ofd_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .edge_time_us(edge_time_us),
        .out_valid(out_valid), .out_ready(out_ready),
        .protocol(protocol), .frame_code(frame_code),
        .frame_bits(frame_bits), .found_now(found_now),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stall per transaction, plus one long hold on request
    initial
    begin
        int w;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            w = calm ? 0 : $urandom_range(0, 11);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                if (hold_len > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold_len) @(posedge clk);
                    hold_len = 0;
                    out_ready <= 1'b1;
                end
                @(posedge clk);
            end
        end
    end

    // offer one item and wait for its transaction; valid stays high into the next item
    task automatic push(input logic [1:0] op, input logic [31:0] t);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        edge_time_us <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op != OP_RESERVED)
            n_items++;
        if (op == OP_RECORD)
            ring_fill++;
        else if (op == OP_CLEAR)
            ring_fill = 0;
    endtask

    task automatic record_after(input longint width);
        now_us = now_us + 32'(width);
        push(OP_RECORD, now_us);
    endtask

    // stop offering and let every pending decode come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] tol, input logic [15:0] bmin,
                             input logic [15:0] bmax, input logic [15:0] nmin);
        drain();
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_BASE_MIN, bmin);
        write_reg(REG_BASE_MAX, bmax);
        write_reg(REG_MIN_FRAME, nmin);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint wobble(input longint w, input int pct);
        longint d;
        d = w * pct / 100;
        return w - d + longint'($urandom_range(0, 32'(2 * d)));
    endfunction

    // one transmission, mostly well-formed: optional clear and filler, reference edge, sync pair, bit pairs, decode
    task automatic send_frame();
        int  set_sel;
        int  nbits, slow, lng, jit;
        longint base;
        logic [27:0] code;
        set_sel = $urandom_range(0, 1) ? 2 : 0;
        nbits = (set_sel == 2) ? 28 : 24;
        slow = (set_sel == 2) ? 23 : 31;
        lng = (set_sel == 2) ? 2 : 3;
        base = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3000) : $urandom_range(60, 1500);
        jit = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 35);
        code = 28'($urandom());
        if (ring_fill > 40 || $urandom_range(0, 3) != 0)
            push(OP_CLEAR, $urandom());
        repeat ($urandom_range(0, 4))
            record_after($urandom_range(1, 5000));
        record_after($urandom_range(5000, 20000));
        record_after(wobble(base, jit));
        record_after(wobble(base * slow, jit));
        for (int b = nbits - 1; b >= 0; b--)
        begin
            // an occasional broken bit pair
            if ($urandom_range(0, 60) == 0)
            begin
                record_after($urandom_range(0, 8000));
                record_after($urandom_range(0, 8000));
            end
            else if (code[b])
            begin
                record_after(wobble(base * lng, jit));
                record_after(wobble(base, jit));
            end
            else
            begin
                record_after(wobble(base, jit));
                record_after(wobble(base * lng, jit));
            end
        end
        push(OP_DECODE, $urandom());
    endtask

    // a few random operations of any kind
    task automatic send_noise();
        int pick;
        repeat ($urandom_range(4, 10))
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                record_after($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4000));
            else if (pick < 15)
                push(OP_DECODE, $urandom());
            else if (pick < 18)
                push(OP_CLEAR, $urandom());
            else
                push(OP_RESERVED, $urandom());
        end
    endtask

    task automatic run_until(input int limit);
        while (n_items < limit)
        begin
            if ($urandom_range(0, 4) == 0)
                calm = !calm;
            if ($urandom_range(0, 9) < 6)
                send_frame();
            else
                send_noise();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_RECORD;
        edge_time_us = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TOLERANCE;
        cfg_data = '0;
        calm = 1'b0;
        hold_len = 0;
        n_items = 0;
        ring_fill = 0;
        now_us = $urandom();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored operation, empty decode, wrapping, zero width and long gaps
        push(OP_RESERVED, 32'hFFFF_FFFF);
        push(OP_DECODE, '0);
        push(OP_RECORD, 32'hFFFF_FFF0);
        push(OP_RECORD, 32'h0000_0010);
        push(OP_RECORD, 32'h0000_0010);
        push(OP_RECORD, 32'h8000_0010);
        push(OP_RECORD, 32'hFFFF_FFFF);
        push(OP_DECODE, '0);
        for (int i = 0; i < 6; i++)
            push(OP_RECORD, 32'hFFFF_FFFF + 32'(i * 300));
        push(OP_DECODE, 32'h5555_5555);
        push(OP_CLEAR, 32'hAAAA_AAAA);
        push(OP_DECODE, '0);
        push(OP_RECORD, '0);
        push(OP_DECODE, '0);
        now_us = '0;
        run_until(170);

        // exact match only, widest base window, decode with any fill
        configure(16'd0, 16'd0, 16'hFFFF, 16'd0);
        run_until(340);

        // largest tolerance, empty base window
        configure(16'd127, 16'hFFFF, 16'd0, 16'd8);
        run_until(420);

        // full ring needed before any search
        configure(16'd100, 16'd50, 16'd2000, 16'd256);
        run_until(560);

        // random settings; first a long output stall so decodes back up
        configure(16'($urandom_range(0, 127)), 16'($urandom_range(0, 200)),
                  16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 60)));
        push(OP_CLEAR, $urandom());
        hold_len = 300;
        calm = 1'b1;
        repeat (8)
            push(OP_DECODE, $urandom());
        calm = 1'b0;
        run_until(760);

        // back to defaults; one decode over a ring that has wrapped
        configure(16'd25, 16'd50, 16'd2000, 16'd8);
        push(OP_CLEAR, $urandom());
        repeat (270)
            record_after($urandom_range(1, 3000));
        push(OP_DECODE, $urandom());
        push(OP_CLEAR, $urandom());
        run_until(ITEM_TARGET);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
